>>> src/wheel30_prime_bitmap_expander_core_assert.svh
// ----------------------------------------------------------------------------
// wheel30 expander assertion macros
// Shared concurrent assertion wrappers for the wheel bitmap expander.
// ----------------------------------------------------------------------------
`ifndef WHEEL30_PRIME_BITMAP_EXPANDER_CORE_ASSERT_SVH
`define WHEEL30_PRIME_BITMAP_EXPANDER_CORE_ASSERT_SVH

// clocked assertion, disabled while reset is high
`define W30_ASSERT_RST(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define W30_ASSERT(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`endif

>>> src/w30pbe_pkg.sv
// ----------------------------------------------------------------------------
// w30pbe_pkg
// Types and constants for the mod-30 wheel prime bitmap expander.
// ----------------------------------------------------------------------------
`default_nettype none

package w30pbe_pkg;

  // field widths
  localparam int BYTE_W    = 8;
  localparam int SPAN_W    = 58;
  localparam int PRIME_W   = 63;
  localparam int RES_W     = 5;
  localparam int NUM_RES   = 8;
  localparam int BIT_IDX_W = 3;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = RES_W;

  // wheel of 30 built as 32 - 2 with two shifts
  localparam int WHEEL_SHL_HI  = 5;
  localparam int WHEEL_SHL_LO  = 1;
  localparam int WHEEL_MODULUS = (1 << WHEEL_SHL_HI) - (1 << WHEEL_SHL_LO);

  typedef logic [RES_W-1:0] residue_t;

  // standard wheel residues at reset
  localparam residue_t WHEEL_RESET [NUM_RES] = '{
    residue_t'(1), residue_t'(7), residue_t'(11), residue_t'(13),
    residue_t'(17), residue_t'(19), residue_t'(23), residue_t'(29)
  };

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BASE,
    ST_EMIT
  } state_t;

  // index of the lowest set bit of a byte
  function automatic logic [BIT_IDX_W-1:0] lowest_bit(input logic [BYTE_W-1:0] m);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> src/wheel30_prime_bitmap_expander_core.sv
// ----------------------------------------------------------------------------
// wheel30_prime_bitmap_expander_core
// Expands a mod-30 wheel prime bitmap into prime values, one per set bit.
// ----------------------------------------------------------------------------
// Each accepted byte covers one block of 30 numbers. The block number is
// span_base when new_span is set, otherwise a running counter that advances
// by one per byte and wraps at 2**BLOCK_BITS. For every set bit, lowest first,
// one result 30 * block + residue is sent, and the final one of the byte
// carries last_of_byte; a zero byte sends nothing but still advances the
// counter. The input is stalled while a byte is in work: the byte is taken
// in the idle state, then in the base state the shared 63-bit adder forms
// 30 * block as (block << 5) - (block << 1), then in the emit state the same
// adder adds the residue for each result. An output stall holds the emit
// state. The eight residues are write-only registers at indexes 0..7 that
// reset to 1, 7, 11, 13, 17, 19, 23, 29; writes to other indexes are
// dropped.
`default_nettype none

module wheel30_prime_bitmap_expander_core
  import w30pbe_pkg::*;
#(
  parameter int BLOCK_BITS = 58
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic [BYTE_W-1:0]     bitmap_byte,
  input  wire logic                  new_span,
  input  wire logic [SPAN_W-1:0]     span_base,
  // output channel
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic [PRIME_W-1:0]    prime_value,
  output      logic                  last_of_byte
);

`include "wheel30_prime_bitmap_expander_core_assert.svh"

  state_t                  state, state_next;
  residue_t                residue [NUM_RES];
  logic [BLOCK_BITS-1:0]   block_counter;
  logic [BLOCK_BITS-1:0]   blk;
  logic [BLOCK_BITS-1:0]   blk_sel;
  logic [BYTE_W-1:0]       mask;
  logic [BYTE_W-1:0]       mask_rest;
  logic [BIT_IDX_W-1:0]    bit_idx;
  logic [PRIME_W-1:0]      base;
  logic [PRIME_W-1:0]      blk_ext;
  logic [PRIME_W-1:0]      add_a, add_b, add_sum;
  logic                    add_cin;
  logic                    in_accept;
  logic                    out_free;
  logic                    base_load;
  logic                    out_load;

  // handshake terms
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // block number of the incoming byte
  assign blk_sel = new_span ? span_base[BLOCK_BITS-1:0] : block_counter;

  // pending bit selection
  assign bit_idx   = lowest_bit(mask);
  assign mask_rest = mask & (mask - BYTE_W'(1));

  // shared adder
  assign blk_ext = PRIME_W'(blk);
  assign add_sum = add_a + add_b + PRIME_W'(add_cin);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_BASE;
      end
      ST_BASE: begin
        state_next = (mask == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && mask_rest == '0) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs and adder operand select
  always_comb begin
    in_stall  = 1'b1;
    base_load = 1'b0;
    out_load  = 1'b0;
    add_a     = base;
    add_b     = PRIME_W'(residue[bit_idx]);
    add_cin   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_BASE: begin
        base_load = 1'b1;
        add_a     = blk_ext << WHEEL_SHL_HI;
        add_b     = ~(blk_ext << WHEEL_SHL_LO);
        add_cin   = 1'b1;
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // residue registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_RES; i++) begin
        residue[i] <= WHEEL_RESET[i];
      end
    end else if (cfg_wr_en && cfg_index < CFG_IDX_W'(NUM_RES)) begin
      residue[cfg_index[BIT_IDX_W-1:0]] <= cfg_data;
    end
  end

  // running block counter and pending bits
  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
      mask          <= '0;
    end else if (in_accept) begin
      block_counter <= blk_sel + BLOCK_BITS'(1);
      mask          <= bitmap_byte;
    end else if (out_load) begin
      mask          <= mask_rest;
    end
  end

  // block and base registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      blk <= blk_sel;
    end
    if (base_load) begin
      base <= add_sum;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      prime_value  <= add_sum;
      last_of_byte <= (mask_rest == '0);
    end
  end

  // assertions
  `W30_ASSERT_RST(a_accept_to_base, clk, rst,
    in_accept |=> state == ST_BASE, "accepted byte did not start base computation")
  `W30_ASSERT_RST(a_emit_has_bits, clk, rst,
    state == ST_EMIT |-> mask != '0, "emit state with no pending bits")
  `W30_ASSERT_RST(a_mid_byte_busy, clk, rst,
    (out_valid && !last_of_byte) |-> (state == ST_EMIT && in_stall),
    "result before the last of a byte while sequencer is not emitting")
  `W30_ASSERT_RST(a_base_exit, clk, rst,
    state == ST_BASE |=> (state == ST_EMIT || state == ST_IDLE),
    "base computation not followed by emit or idle")

endmodule

`default_nettype wire
